// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPLY(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== rtl/mi4_pkg.sv =====
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants and types of the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;
  localparam int DIM_DEFAULT = 4;
  localparam int FRAC_DEFAULT = 16;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SRCH, ST_SWAP, ST_CHK, ST_DIV, ST_SCALE, ST_SCALE_W,
    ST_ELIM_RD, ST_ELIM_MUL, ST_ELIM_W, ST_UNSWAP, ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== rtl/mi4_divider.sv =====
// ----------------------------------------------------------------------------
// mi4_divider
// Restoring divider: one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module mi4_divider #(
  parameter int NW = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [NW-1:0] quo
);
  logic [NW-1:0] nreg;
  logic [32:0]   rem;
  logic [$clog2(NW+1)-1:0] cnt;
  logic          busy;
  logic [32:0]   sh;

  assign sh = {rem[31:0], nreg[NW-1]};
  assign quo = nreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        nreg <= num;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (sh >= {1'b0, den}) begin
          rem  <= sh - {1'b0, den};
          nreg <= {nreg[NW-2:0], 1'b1};
        end else begin
          rem  <= sh;
          nreg <= {nreg[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(NW+1))'(NW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/matrix_inverse_4x4.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// Gauss-Jordan inverse with full pivoting in signed fixed point.
// ----------------------------------------------------------------------------
// Input channel: element_value items, DIM*DIM per matrix in row-major order,
// taken one per cycle while the block is loading.
// Output channel: DIM*DIM items with result_value, element_index, singular
// and last_element; last_element marks the final item of the run.
// After the last input item the block stalls its input while it works:
// per pivot step a search over the unused rows and columns, a row swap, a
// pivot check, a reciprocal from the serial divider, a scale of the pivot
// row and the elimination of the other rows through the product register;
// then the column unswap. A singular matrix finishes early.
// Results go out one per cycle; a stall holds the current item and the
// sequencer waits. A singular matrix returns the input unchanged with
// singular set on every item.
// Reset returns the block to loading with no item pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module matrix_inverse_4x4 #(
  parameter int DIM = mi4_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mi4_pkg::FRAC_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] element_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic [3:0]         element_index,
  output logic               singular,
  output logic               last_element
);
  localparam int N = DIM * DIM;
  localparam int IW = $clog2(N);
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int NW = 2 * FRAC_BITS + 2;

  mi4_pkg::state_t state, state_next;

  logic signed [31:0] wm [N];
  logic signed [31:0] sv [N];
  logic [1:0] use_cnt [DIM];
  logic [DW-1:0] prow_rec [DIM];
  logic [DW-1:0] pcol_rec [DIM];
  logic [IW:0] ld;
  logic        sing;
  logic [DW-1:0] step, prow, pcol, jj, kk;
  logic [31:0] big;
  logic signed [31:0] rc, save, pvt;
  logic signed [63:0] prod;
  logic [IW-1:0] oidx;

  logic        div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [31:0] dmag;

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] fxr(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return mi4_pkg::sat32(66'(q));
  endfunction

  function automatic logic [IW-1:0] ix(input logic [DW-1:0] r, input logic [DW-1:0] c);
    return IW'(r * DIM + c);
  endfunction

  assign dmag = mag(pvt);
  assign div_num = (NW'(1) << (2*FRAC_BITS)) + NW'(dmag >> 1);

  mi4_divider #(.NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(dmag),
    .done(div_done), .quo(div_quo)
  );

  assign in_stall = (state != mi4_pkg::ST_LOAD);
  assign out_valid = (state == mi4_pkg::ST_OUT);
  assign result_value = sing ? sv[oidx] : wm[oidx];
  assign element_index = 4'(oidx);
  assign singular = sing;
  assign last_element = (oidx == IW'(N - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= mi4_pkg::ST_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      mi4_pkg::ST_LOAD:
        if (in_valid && ld == (IW+1)'(N - 1)) state_next = mi4_pkg::ST_SRCH;
      mi4_pkg::ST_SRCH:
        if (jj == DW'(DIM - 1) && kk == DW'(DIM - 1)) state_next = mi4_pkg::ST_SWAP;
      mi4_pkg::ST_SWAP:
        if (kk == DW'(DIM - 1)) state_next = mi4_pkg::ST_CHK;
      mi4_pkg::ST_CHK:
        if (sing || pvt == 0) state_next = mi4_pkg::ST_OUT;
        else begin
          div_start = 1'b1;
          state_next = mi4_pkg::ST_DIV;
        end
      mi4_pkg::ST_DIV:
        if (div_done) state_next = mi4_pkg::ST_SCALE;
      mi4_pkg::ST_SCALE: state_next = mi4_pkg::ST_SCALE_W;
      mi4_pkg::ST_SCALE_W:
        state_next = (kk == DW'(DIM - 1)) ? mi4_pkg::ST_ELIM_RD : mi4_pkg::ST_SCALE;
      mi4_pkg::ST_ELIM_RD: state_next = mi4_pkg::ST_ELIM_MUL;
      mi4_pkg::ST_ELIM_MUL: state_next = mi4_pkg::ST_ELIM_W;
      mi4_pkg::ST_ELIM_W:
        if ((jj == DW'(DIM - 1) || (jj == DW'(DIM - 2) && pcol == DW'(DIM - 1)))
            && kk == DW'(DIM - 1))
          state_next = (step == DW'(DIM - 1)) ? mi4_pkg::ST_UNSWAP : mi4_pkg::ST_SRCH;
        else state_next = mi4_pkg::ST_ELIM_RD;
      mi4_pkg::ST_UNSWAP:
        if (jj == '0 && kk == DW'(DIM - 1)) state_next = mi4_pkg::ST_OUT;
      mi4_pkg::ST_OUT:
        if (!out_stall && oidx == IW'(N - 1)) state_next = mi4_pkg::ST_LOAD;
      default: state_next = mi4_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    logic [31:0] m;
    logic [IW-1:0] a, b;
    logic [66:0] qd;
    logic signed [31:0] t;
    if (rst) begin
      ld <= '0;
      sing <= 1'b0;
      oidx <= '0;
      for (int i = 0; i < DIM; i++) use_cnt[i] <= '0;
    end else begin
      unique case (state)
        mi4_pkg::ST_LOAD:
          if (in_valid) begin
            wm[ld[IW-1:0]] <= element_value;
            sv[ld[IW-1:0]] <= element_value;
            if (ld == (IW+1)'(N - 1)) begin
              ld <= '0;
              sing <= 1'b0;
              step <= '0;
              jj <= '0; kk <= '0; big <= '0; prow <= '0; pcol <= '0;
              for (int i = 0; i < DIM; i++) use_cnt[i] <= '0;
            end else ld <= ld + 1'b1;
          end
        mi4_pkg::ST_SRCH: begin
          if (use_cnt[jj] != 2'd1) begin
            if (use_cnt[kk] == 2'd0) begin
              m = mag(wm[ix(jj, kk)]);
              if (m >= big) begin
                big <= m; prow <= jj; pcol <= kk;
              end
            end else if (use_cnt[kk] > 2'd1) sing <= 1'b1;
          end
          if (kk == DW'(DIM - 1)) begin
            kk <= '0;
            if (jj == DW'(DIM - 1)) jj <= '0; else jj <= jj + 1'b1;
          end else kk <= kk + 1'b1;
        end
        mi4_pkg::ST_SWAP: begin
          if (kk == '0 && !sing && use_cnt[pcol] < 2'd3)
            use_cnt[pcol] <= use_cnt[pcol] + 1'b1;
          if (prow != pcol) begin
            wm[ix(prow, kk)] <= wm[ix(pcol, kk)];
            wm[ix(pcol, kk)] <= wm[ix(prow, kk)];
          end
          if (kk == pcol) pvt <= wm[ix(prow, kk)];
          prow_rec[step] <= prow;
          pcol_rec[step] <= pcol;
          if (kk == DW'(DIM - 1)) kk <= '0; else kk <= kk + 1'b1;
        end
        mi4_pkg::ST_CHK:
          if (!sing && pvt == 0) sing <= 1'b1;
        mi4_pkg::ST_DIV:
          if (div_done) begin
            qd = 67'(div_quo);
            if (qd > 67'h80000000) qd = 67'h80000000;
            if (pvt[31]) rc <= mi4_pkg::sat32(-(66'(qd)));
            else rc <= mi4_pkg::sat32(66'(qd));
            wm[ix(pcol, pcol)] <= 32'sd1 <<< FRAC_BITS;
            kk <= '0;
          end
        mi4_pkg::ST_SCALE:
          prod <= 64'(wm[ix(pcol, kk)]) * 64'(rc);
        mi4_pkg::ST_SCALE_W: begin
          wm[ix(pcol, kk)] <= fxr(prod);
          if (kk == DW'(DIM - 1)) begin
            kk <= '0;
            jj <= (pcol == '0) ? DW'(1) : '0;
          end else kk <= kk + 1'b1;
        end
        mi4_pkg::ST_ELIM_RD:
          if (kk == '0) begin
            save <= wm[ix(jj, pcol)];
            wm[ix(jj, pcol)] <= '0;
            prod <= 64'(wm[ix(pcol, kk)]) * 64'(wm[ix(jj, pcol)]);
          end else prod <= 64'(wm[ix(pcol, kk)]) * 64'(save);
        mi4_pkg::ST_ELIM_MUL:
          prod <= 64'(fxr(prod));
        mi4_pkg::ST_ELIM_W: begin
          t = (kk == pcol) ? 32'sd0 : wm[ix(jj, kk)];
          wm[ix(jj, kk)] <= mi4_pkg::sat32(66'(t) - 66'(prod));
          if (kk == DW'(DIM - 1)) begin
            kk <= '0;
            if (jj == DW'(DIM - 1) || (jj == DW'(DIM - 2) && pcol == DW'(DIM - 1))) begin
              jj <= (step == DW'(DIM - 1)) ? DW'(DIM - 1) : '0;
              step <= step + 1'b1;
              big <= '0; prow <= '0; pcol <= '0;
            end else if (jj + 1'b1 == pcol) jj <= jj + DW'(2);
            else jj <= jj + 1'b1;
          end else kk <= kk + 1'b1;
        end
        mi4_pkg::ST_UNSWAP: begin
          a = ix(kk, prow_rec[jj]);
          b = ix(kk, pcol_rec[jj]);
          if (prow_rec[jj] != pcol_rec[jj]) begin
            wm[a] <= wm[b];
            wm[b] <= wm[a];
          end
          if (kk == DW'(DIM - 1)) begin
            kk <= '0;
            jj <= jj - 1'b1;
          end else kk <= kk + 1'b1;
        end
        mi4_pkg::ST_OUT:
          if (!out_stall) oidx <= (oidx == IW'(N - 1)) ? '0 : oidx + 1'b1;
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLY(a_stall_busy, out_valid, in_stall)
  `ASSERT_NEXT(a_last_load, out_valid && !out_stall && last_element, !in_stall)
  `ASSERT_IMPLY(a_ld_range, !in_stall, ld < (IW+1)'(N))
endmodule

// ===== tb/tb_matrix_inverse_4x4.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_inverse_4x4
// Self-checking bench for the 4x4 fixed-point Gauss-Jordan inverse: streams
// matrices through the element channel, predicts every inverse element (or
// the unchanged input for singular matrices) and checks the result stream.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_4x4;
  localparam int N = 4;
  localparam int FB = 16;
  localparam int NN = N * N;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               sing;
    logic               last;
  } inv_result_t;

  class inverse_scoreboard;
    logic signed [31:0] mat[NN];
    int                 fill;
    inv_result_t        pending[$];
    int                 errors;
    int                 checked;
    int                 sing_runs;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      sing_runs = 0;
    endfunction

    function logic signed [31:0] clip(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b) + (66'sd1 <<< (FB - 1));
      return clip(p >>> FB);
    endfunction

    function logic signed [31:0] qrecip(logic signed [31:0] p);
      logic [63:0] d;
      logic [63:0] q;
      d = p < 0 ? 64'(-66'(p)) : 64'(p);
      q = ((64'd1 << (2 * FB)) + d / 2) / d;
      if (q > 64'h80000000) q = 64'h80000000;
      return p < 0 ? clip(-66'(q)) : clip(66'(q));
    endfunction

    function void note_element(logic signed [31:0] v);
      logic signed [31:0] w[NN];
      logic signed [31:0] t, rc, sv;
      int used[N];
      int prow[N], pcol[N];
      logic [31:0] big, m;
      bit sing;
      int r, c;
      mat[fill] = v;
      fill++;
      if (fill < NN) return;
      fill = 0;
      w = mat;
      sing = 0;
      foreach (used[i]) used[i] = 0;
      for (int i = 0; i < N && !sing; i++) begin
        r = 0; c = 0; big = 0;
        for (int j = 0; j < N; j++) begin
          if (used[j] == 1) continue;
          for (int k = 0; k < N; k++) begin
            if (used[k] == 0) begin
              m = w[j*N+k] < 0 ? -w[j*N+k] : w[j*N+k];
              if (m >= big) begin big = m; r = j; c = k; end
            end else if (used[k] > 1) sing = 1;
          end
        end
        if (sing) break;
        if (used[c] < 3) used[c]++;
        if (r != c)
          for (int k = 0; k < N; k++) begin
            t = w[r*N+k]; w[r*N+k] = w[c*N+k]; w[c*N+k] = t;
          end
        prow[i] = r; pcol[i] = c;
        if (w[c*N+c] == 0) begin sing = 1; break; end
        rc = qrecip(w[c*N+c]);
        w[c*N+c] = 32'sd1 <<< FB;
        for (int k = 0; k < N; k++) w[c*N+k] = qmul(w[c*N+k], rc);
        for (int j = 0; j < N; j++) begin
          if (j == c) continue;
          sv = w[j*N+c];
          w[j*N+c] = 0;
          for (int k = 0; k < N; k++)
            w[j*N+k] = clip(66'(w[j*N+k]) - 66'(qmul(w[c*N+k], sv)));
        end
      end
      if (!sing)
        for (int j = N - 1; j >= 0; j--)
          if (prow[j] != pcol[j])
            for (int k = 0; k < N; k++) begin
              t = w[k*N+prow[j]]; w[k*N+prow[j]] = w[k*N+pcol[j]]; w[k*N+pcol[j]] = t;
            end
      if (sing) sing_runs++;
      for (int n = 0; n < NN; n++)
        pending.push_back('{sing ? mat[n] : w[n], 4'(n), sing, n == NN - 1});
    endfunction

    function void check_result(inv_result_t got);
      inv_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result value=%0d index=%0d", got.value, got.index);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.value !== exp.value) begin
        $error("result_value expected %0d actual %0d", exp.value, got.value); errors++;
      end
      if (got.index !== exp.index) begin
        $error("element_index expected %0d actual %0d", exp.index, got.index); errors++;
      end
      if (got.sing !== exp.sing) begin
        $error("singular expected %0b actual %0b", exp.sing, got.sing); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_element expected %0b actual %0b", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] element_value;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] result_value;
  logic [3:0] element_index;
  logic singular;
  logic last_element;

  inverse_scoreboard sb;
  bit idle_on;
  bit rx_hold;
  int sent;

  matrix_inverse_4x4 i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
    .element_index(element_index), .singular(singular), .last_element(last_element)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("** matrix_inverse_4x4: FAILED **");
    $finish;
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result('{result_value, element_index, singular, last_element});

  // receiver: random stall bursts, or a long hold when asked
  initial begin
    int n;
    out_stall = 0;
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        rx_hold = 0;
        out_stall <= 0;
        @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= 0;
        @(posedge clk);
      end
    end
  end

  task automatic send_element(logic signed [31:0] v);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_element(v);
    sent++;
  endtask

  task automatic send_matrix(logic signed [31:0] m[NN]);
    for (int i = 0; i < NN; i++) send_element(m[i]);
  endtask

  function automatic logic signed [31:0] rand_elem(int kind);
    case (kind)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      2: return $signed($urandom_range(0, 32'h1000)) - 32'sh800;
      default: return 0;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] m[NN];
    int kind;
    sb = new();
    idle_on = 0;
    rx_hold = 0;
    sent = 0;
    rst = 1;
    in_valid = 0;
    element_value = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // identity, scaled diagonal with extremes, zero matrix, rank-deficient, ramp with extremes
    foreach (m[i]) m[i] = (i % 5 == 0) ? 32'sh10000 : 0;
    send_matrix(m);
    foreach (m[i]) m[i] = 0;
    m[0] = 32'sh7fffffff; m[5] = 32'sh80000000; m[10] = 1; m[15] = -1;
    send_matrix(m);
    foreach (m[i]) m[i] = 0;
    send_matrix(m);
    foreach (m[i]) m[i] = (i < 4) ? 32'sh10000 : 32'sh10000 * (i % 4 + 1);
    send_matrix(m);
    foreach (m[i]) m[i] = 32'(i) * 32'sh3000 - 32'sh20000;
    m[3] = 32'sh7fffffff; m[12] = 32'sh80000000;
    send_matrix(m);
    wait_drained();

    // hold the receiver off while the sender keeps offering
    rx_hold = 1;
    idle_on = 1;
    for (int r = 0; r < 3; r++) begin
      foreach (m[i]) m[i] = rand_elem(1);
      send_matrix(m);
    end
    wait_drained();

    for (int r = 0; r < 11; r++) begin
      kind = $urandom_range(0, 9);
      if (r == 7) idle_on = 0;
      foreach (m[i]) m[i] = rand_elem(kind < 2 ? 0 : (kind < 6 ? 1 : 2));
      if (kind == 9) begin
        m[$urandom_range(4, 7)] = 0;
        m[$urandom_range(0, 3)] = 0;
      end
      if (kind == 8) for (int k = 0; k < N; k++) m[8 + k] = m[4 + k];
      send_matrix(m);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d elements; checked %0d results, %0d singular matrices.",
             sent, sb.checked, sb.sing_runs);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** matrix_inverse_4x4: PASSED **");
    else
      $display("** matrix_inverse_4x4: FAILED **");
    $finish;
  end
endmodule
